[rtl/core/csvfs_pkg.sv]
// Package for the CSV field splitter: byte classes, parse modes, queue entry
// and result types, and the fixed byte codes.
// No dependencies.
package csvfs_pkg;

    // Fixed widths of the payload fields.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned ERROR_W = 2;

    // Width of the packed result data: byte, field end, index, error code.
    localparam int unsigned RES_DATA_W = BYTE_W + 1 + INDEX_W + ERROR_W;

    // Special byte codes.
    localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'h22;
    localparam logic [BYTE_W-1:0] COMMA_BYTE = 8'h2C;
    localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

    // Byte class decided by the front end.
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_COMMA = 2'd1,
        KIND_QUOTE = 2'd2,
        KIND_EOL   = 2'd3
    } t_kind;

    // Parse mode of the back end.
    typedef enum logic [1:0] {
        MODE_PLAIN      = 2'd0,
        MODE_QUOTED     = 2'd1,
        MODE_QUOTE_SEEN = 2'd2,
        MODE_DROP       = 2'd3
    } t_mode;

    // Error codes carried with each result.
    typedef enum logic [ERROR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_UNCLOSED   = 2'd1,
        ERR_BAD_QUOTE  = 2'd2,
        ERR_TOO_MANY   = 2'd3
    } t_error;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
    } t_item;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic   valid;
        t_item  item;
    } t_q_head;

    // One result item.
    typedef struct packed {
        t_error              error_code;
        logic [INDEX_W-1:0]  field_index;
        logic                record_end;
        logic                field_end;
        logic                has_byte;
        logic [BYTE_W-1:0]   data_byte;
    } t_result;

endpackage

[rtl/core/csvfs_front.sv]
// Front end of the CSV field splitter: accepts bytes, classifies them and
// holds them in a two-entry queue for the back end.
// Depends on csvfs_pkg.
module csvfs_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [csvfs_pkg::BYTE_W-1:0] i_ch,
    input  logic                   i_line_end,
    output csvfs_pkg::t_q_head     o_head,
    input  logic                   i_pop
);
    import csvfs_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    t_item       w_item;
    logic        w_push;

    // Classify the incoming byte; a zero byte ends the line too.
    always_comb begin
        w_item.data = i_ch;
        if (i_line_end || (i_ch == NUL_BYTE)) begin
            w_item.kind = KIND_EOL;
        end else if (i_ch == COMMA_BYTE) begin
            w_item.kind = KIND_COMMA;
        end else if (i_ch == QUOTE_BYTE) begin
            w_item.kind = KIND_QUOTE;
        end else begin
            w_item.kind = KIND_OTHER;
        end
    end

    assign o_ready = (r_count != 2'd2);
    assign w_push  = i_valid && o_ready;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

[rtl/core/csvfs_back.sv]
// Back end of the CSV field splitter: runs the quote/field mode machine on
// classified bytes and holds each result in an output register.
// Depends on csvfs_pkg.
module csvfs_back #(
    parameter int unsigned FIELD_LIMIT = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csvfs_pkg::t_q_head  i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output csvfs_pkg::t_result  o_result
);
    import csvfs_pkg::*;

    localparam logic [INDEX_W:0] LIMIT = (INDEX_W+1)'(FIELD_LIMIT);

    t_mode               r_mode;
    t_mode               n_mode;
    logic [INDEX_W-1:0]  r_count;
    logic [INDEX_W-1:0]  n_count;
    logic                r_out_valid;
    t_result             r_out;
    logic                w_res_valid;
    t_result             w_res;
    logic                w_at_limit;
    logic [INDEX_W:0]    w_next_idx;

    // Pop the queue head whenever the output register is free or drains.
    assign o_pop = i_head.valid && (!r_out_valid || i_ready);

    assign w_next_idx = {1'b0, r_count} + (INDEX_W+1)'(1);
    assign w_at_limit = (w_next_idx >= LIMIT);

    // Next mode and field count.
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        unique case (r_mode)
            MODE_PLAIN, MODE_QUOTE_SEEN: begin
                unique case (i_head.item.kind)
                    KIND_EOL: begin
                        n_mode  = MODE_PLAIN;
                        n_count = '0;
                    end
                    KIND_COMMA: begin
                        if (w_at_limit) begin
                            n_mode = MODE_DROP;
                        end else begin
                            n_mode  = MODE_PLAIN;
                            n_count = w_next_idx[INDEX_W-1:0];
                        end
                    end
                    KIND_QUOTE: begin
                        n_mode = MODE_QUOTED;
                    end
                    default: begin
                        if (r_mode == MODE_QUOTE_SEEN) begin
                            n_mode = MODE_DROP;
                        end
                    end
                endcase
            end
            MODE_QUOTED: begin
                if (i_head.item.kind == KIND_EOL) begin
                    n_mode  = MODE_PLAIN;
                    n_count = '0;
                end else if (i_head.item.kind == KIND_QUOTE) begin
                    n_mode = MODE_QUOTE_SEEN;
                end
            end
            default: begin
                if (i_head.item.kind == KIND_EOL) begin
                    n_mode  = MODE_PLAIN;
                    n_count = '0;
                end
            end
        endcase
    end

    // Result for the current item, if it causes one.
    always_comb begin
        w_res_valid       = 1'b0;
        w_res.data_byte   = '0;
        w_res.has_byte    = 1'b0;
        w_res.field_end   = 1'b0;
        w_res.record_end  = 1'b0;
        w_res.field_index = r_count;
        w_res.error_code  = ERR_NONE;
        unique case (r_mode)
            MODE_PLAIN, MODE_QUOTE_SEEN: begin
                unique case (i_head.item.kind)
                    KIND_EOL: begin
                        w_res_valid      = 1'b1;
                        w_res.field_end  = 1'b1;
                        w_res.record_end = 1'b1;
                    end
                    KIND_COMMA: begin
                        w_res_valid     = 1'b1;
                        w_res.field_end = 1'b1;
                        if (w_at_limit) begin
                            w_res.error_code = ERR_TOO_MANY;
                        end
                    end
                    KIND_QUOTE: begin
                        // A doubled quote inside quotes gives one literal quote.
                        if (r_mode == MODE_QUOTE_SEEN) begin
                            w_res_valid     = 1'b1;
                            w_res.data_byte = QUOTE_BYTE;
                            w_res.has_byte  = 1'b1;
                        end
                    end
                    default: begin
                        w_res_valid = 1'b1;
                        if (r_mode == MODE_QUOTE_SEEN) begin
                            w_res.field_end  = 1'b1;
                            w_res.error_code = ERR_BAD_QUOTE;
                        end else begin
                            w_res.data_byte = i_head.item.data;
                            w_res.has_byte  = 1'b1;
                        end
                    end
                endcase
            end
            MODE_QUOTED: begin
                if (i_head.item.kind == KIND_EOL) begin
                    w_res_valid      = 1'b1;
                    w_res.field_end  = 1'b1;
                    w_res.record_end = 1'b1;
                    w_res.error_code = ERR_UNCLOSED;
                end else if (i_head.item.kind != KIND_QUOTE) begin
                    w_res_valid     = 1'b1;
                    w_res.data_byte = i_head.item.data;
                    w_res.has_byte  = 1'b1;
                end
            end
            default: begin
                // Dropping the rest of a line: only its end reports.
                if (i_head.item.kind == KIND_EOL) begin
                    w_res_valid       = 1'b1;
                    w_res.record_end  = 1'b1;
                    w_res.field_index = '0;
                end
            end
        endcase
    end

    // Mode registers advance on each popped item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_count <= '0;
        end else if (o_pop) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= w_res_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/core/csv_field_splitter_top.sv]
// CSV field splitter, top level: an accepted byte is written into the queue,
// then the mode step of the back end takes it into the output register, where
// its result appears on the output. Throughput is one byte per cycle while the
// output is accepted; the two-entry queue lets both sides stall freely.
// Reset (synchronous, active low) empties the queue and output register and
// returns the parser to the start of an unquoted field with field index zero.
module csv_field_splitter_top #(
    parameter int unsigned MAX_FIELD_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // line_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [csvfs_pkg::RES_DATA_W-1:0] o_m_tdata, // [7:0] data_byte,
                                     // [8] field_end, [13:9] field_index,
                                     // [15:14] error_code
    output logic        o_m_tuser,   // has_byte
    output logic        o_m_tlast    // record_end
);
    import csvfs_pkg::*;

    localparam int unsigned FIELD_LIMIT = (MAX_FIELD_COUNT > 32) ? 32 : MAX_FIELD_COUNT;

    t_q_head  w_head;
    logic     w_pop;
    t_result  w_result;

    // Byte classifier and queue.
    csvfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_ch       (i_s_tdata),
        .i_line_end (i_s_tlast),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // Mode machine and output register.
    csvfs_back #(
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = {w_result.error_code, w_result.field_index,
                        w_result.field_end, w_result.data_byte};
    assign o_m_tuser = w_result.has_byte;
    assign o_m_tlast = w_result.record_end;

`ifndef SYNTHESIS
    // An unclosed quote always closes both the field and the record.
    a_unclosed_ends_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_result.error_code == ERR_UNCLOSED))
        |-> (w_result.field_end && w_result.record_end))
        else $error("unclosed-quote result without field and record end");

    // A record end without a field end only follows an error, with index zero.
    a_drop_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_result.record_end && !w_result.field_end)
        |-> ((w_result.field_index == '0) && (w_result.error_code == ERR_NONE)))
        else $error("dropped-line end carries index or error");

    // The field index never reaches the field limit.
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({1'b0, w_result.field_index} < (INDEX_W+1)'(FIELD_LIMIT)))
        else $error("field index beyond limit");

    // A content byte never comes with a boundary or an error.
    a_byte_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_result.has_byte)
        |-> (!w_result.field_end && !w_result.record_end
             && (w_result.error_code == ERR_NONE)))
        else $error("content byte mixed with boundary");
`endif

endmodule

[test/tb_top.sv]
// Self-checking bench for the CSV field splitter: streams CSV lines in byte by byte,
// predicts every result from its own model of the parse modes, and checks the output stream.
// Depends on csvfs_pkg and csv_field_splitter_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csvfs_pkg::*;

    localparam int unsigned FIELD_COUNT_CAP = 32;
    localparam int unsigned FIELD_LIMIT = (FIELD_COUNT_CAP > 32) ? 32 : FIELD_COUNT_CAP;
    localparam int unsigned TARGET_ITEMS = 420;
    localparam int unsigned HOLD_CYCLES  = 200;

    // One byte of a line as the sender offers it.
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } t_csv_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [RES_DATA_W-1:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    csv_field_splitter_top #(
        .MAX_FIELD_COUNT(FIELD_COUNT_CAP)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Bytes waiting to be offered, and results still owed by the splitter.
    t_csv_byte line_bytes_q[$];
    t_result   split_results_q[$];

    // Predictor state: parse mode and index of the current field.
    t_mode       parse_state = MODE_PLAIN;
    logic [4:0]  cur_field = '0;

    int unsigned total_items = 0;
    int unsigned lines_built = 0;
    int unsigned accepted_items = 0;
    int unsigned results_seen = 0;
    int unsigned error_results = 0;
    int unsigned too_many_hits = 0;
    int unsigned input_stalls = 0;
    int unsigned mismatch_count = 0;
    logic        s_taken = 1'b0;
    logic        rx_hold = 1'b0;

    // Clock generation.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    // A comma closes the current field, or overflows the field count.
    function automatic void close_field_on_comma(output t_result r);
        r = '0;
        r.field_end   = 1'b1;
        r.field_index = cur_field;
        if (cur_field + 1 >= FIELD_LIMIT) begin
            r.error_code = ERR_TOO_MANY;
            parse_state  = MODE_DROP;
        end else begin
            r.error_code = ERR_NONE;
            cur_field    = cur_field + 5'd1;
            parse_state  = MODE_PLAIN;
        end
    endfunction

    // The end of a line closes the last field and the record.
    function automatic void close_line(output t_result r);
        r = '0;
        r.field_end   = 1'b1;
        r.record_end  = 1'b1;
        r.field_index = cur_field;
        r.error_code  = ERR_NONE;
        parse_state   = MODE_PLAIN;
        cur_field     = '0;
    endfunction

    // Advance the parse by one byte; produced says whether a result comes out.
    function automatic void split_csv_byte(input logic [7:0] ch, input logic eol_in,
                                           output bit produced, output t_result r);
        logic eol;
        eol = eol_in || (ch == NUL_BYTE);
        r = '0;
        produced = 1'b1;
        case (parse_state)
            MODE_PLAIN: begin
                if (eol) close_line(r);
                else if (ch == COMMA_BYTE) close_field_on_comma(r);
                else if (ch == QUOTE_BYTE) begin
                    parse_state = MODE_QUOTED;
                    produced = 1'b0;
                end else begin
                    r.data_byte   = ch;
                    r.has_byte    = 1'b1;
                    r.field_index = cur_field;
                end
            end
            MODE_QUOTED: begin
                if (eol) begin
                    r.field_end   = 1'b1;
                    r.record_end  = 1'b1;
                    r.field_index = cur_field;
                    r.error_code  = ERR_UNCLOSED;
                    parse_state   = MODE_PLAIN;
                    cur_field     = '0;
                end else if (ch == QUOTE_BYTE) begin
                    parse_state = MODE_QUOTE_SEEN;
                    produced = 1'b0;
                end else begin
                    r.data_byte   = ch;
                    r.has_byte    = 1'b1;
                    r.field_index = cur_field;
                end
            end
            MODE_QUOTE_SEEN: begin
                if (eol) close_line(r);
                else if (ch == COMMA_BYTE) close_field_on_comma(r);
                else if (ch == QUOTE_BYTE) begin
                    // A doubled quote is one literal quote.
                    parse_state   = MODE_QUOTED;
                    r.data_byte   = QUOTE_BYTE;
                    r.has_byte    = 1'b1;
                    r.field_index = cur_field;
                end else begin
                    r.field_end   = 1'b1;
                    r.field_index = cur_field;
                    r.error_code  = ERR_BAD_QUOTE;
                    parse_state   = MODE_DROP;
                end
            end
            default: begin
                // Dropping the rest of a line: only its end gives a result.
                if (eol) begin
                    r.record_end = 1'b1;
                    parse_state  = MODE_PLAIN;
                    cur_field    = '0;
                end else begin
                    produced = 1'b0;
                end
            end
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] ch, input logic eol);
        t_csv_byte b;
        b.ch  = ch;
        b.eol = eol;
        line_bytes_q.push_back(b);
        total_items++;
        if (eol || ch == NUL_BYTE) lines_built++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    // A byte that is plain content: not a comma, a quote or a zero.
    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == COMMA_BYTE || b == QUOTE_BYTE);
        return b;
    endfunction

    // Line end, either flagged by tlast with any byte or given as a zero byte.
    task automatic push_line_end();
        if ($urandom_range(0, 3) == 0) push_byte(NUL_BYTE, 1'b0);
        else push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // One random line: mostly well-formed fields, some wide lines that hit
    // the field limit, some broken quoting and some raw noise.
    task automatic add_random_line(input bit wide);
        int unsigned pick;
        int unsigned nfields;
        int unsigned len;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (wide || pick < 6) begin
            nfields = $urandom_range(29, 36);
            for (int f = 0; f < nfields; f++) begin
                if (f != 0) push_byte(COMMA_BYTE, 1'b0);
                if ($urandom_range(0, 1) == 0) push_byte(pick_plain_byte(), 1'b0);
            end
            push_line_end();
        end else if (pick < 82) begin
            nfields = $urandom_range(1, 6);
            for (int f = 0; f < nfields; f++) begin
                if (f != 0) push_byte(COMMA_BYTE, 1'b0);
                len = $urandom_range(0, 5);
                if ($urandom_range(0, 2) == 0) begin
                    // Quoted field: commas and doubled quotes are content.
                    push_byte(QUOTE_BYTE, 1'b0);
                    for (int k = 0; k < len; k++) begin
                        b = ($urandom_range(0, 4) == 0) ? COMMA_BYTE
                                                        : 8'($urandom_range(1, 255));
                        push_byte(b, 1'b0);
                        if (b == QUOTE_BYTE) push_byte(QUOTE_BYTE, 1'b0);
                    end
                    if ($urandom_range(0, 11) != 0) push_byte(QUOTE_BYTE, 1'b0);
                    if ($urandom_range(0, 11) == 0) push_byte(pick_plain_byte(), 1'b0);
                end else begin
                    for (int k = 0; k < len; k++) push_byte(pick_plain_byte(), 1'b0);
                end
            end
            push_line_end();
        end else begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 3))
                    0: push_byte(COMMA_BYTE, 1'b0);
                    1: push_byte(QUOTE_BYTE, 1'b0);
                    default: push_byte(8'($urandom_range(0, 255)),
                                       $urandom_range(0, 7) == 0);
                endcase
            end
            push_line_end();
        end
    endtask

    // Stimulus build, reset, and the end of the run.
    initial begin
        // Extreme bytes, comma inside quotes, doubled quote, quote then line end.
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_text(",\"a,\"\"b\"");
        push_byte(8'hAA, 1'b1);
        // Quote in mid-field opens quotes; a zero byte ends the line inside them.
        push_text("a\"c");
        push_byte(NUL_BYTE, 1'b0);
        // Bad byte after a closing quote; the rest of the line is dropped.
        push_text("\"q\"z,w");
        push_byte(8'h00, 1'b1);
        // Empty quoted field closed by a comma, then an empty line.
        push_text("\"\",");
        push_byte(8'h5A, 1'b1);
        push_byte(8'h00, 1'b1);

        add_random_line(1'b1);
        while (total_items < TARGET_ITEMS) add_random_line(1'b0);

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (accepted_items != total_items) @(posedge i_clk);
        while (split_results_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Streamed %0d bytes in %0d lines; checked %0d results,",
                 total_items, lines_built, results_seen);
        $display("%0d of them errors (%0d field overflows); input held back on %0d cycles.",
                 error_results, too_many_hits, input_stalls);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Long receiver hold-off once traffic is flowing, so the splitter fills up.
    initial begin
        while (accepted_items < 150) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Sender: bursts of random length with random gaps between them.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(negedge i_clk) begin
        logic      next_valid;
        t_csv_byte b;
        if (i_rst_n && !(i_s_tvalid && !s_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (line_bytes_q.size() > 0) begin
                b = line_bytes_q.pop_front();
                next_valid = 1'b1;
                i_s_tdata <= b.ch;
                i_s_tlast <= b.eol;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
            i_s_tvalid <= next_valid;
        end
    end

    // Receiver: drives ready from a stall pattern that it picks anew at random.
    int unsigned rx_cycle = 0;
    int unsigned rx_pattern = 0;
    always @(negedge i_clk) begin
        logic ready;
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_pattern = $urandom_range(0, 3);
        case (rx_pattern)
            0: ready = 1'b1;
            1: ready = 1'($urandom_range(0, 1));
            2: ready = (rx_cycle % 4 == 0);
            default: ready = ($urandom_range(0, 7) != 0);
        endcase
        i_m_tready <= i_rst_n && ready && !rx_hold;
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin
        bit      produced;
        t_result want;
        t_result got;
        string   bad_fields;
        if (!i_rst_n) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && !o_s_tready) input_stalls <= input_stalls + 1;

            if (o_m_tvalid && i_m_tready) begin
                got.data_byte   = o_m_tdata[7:0];
                got.field_end   = o_m_tdata[8];
                got.field_index = o_m_tdata[13:9];
                got.error_code  = t_error'(o_m_tdata[15:14]);
                got.has_byte    = o_m_tuser;
                got.record_end  = o_m_tlast;
                results_seen <= results_seen + 1;
                if (split_results_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result: byte %h has %b fe %b re %b idx %0d err %0d",
                                 $realtime, got.data_byte, got.has_byte, got.field_end,
                                 got.record_end, got.field_index, got.error_code);
                end else begin
                    want = split_results_q.pop_front();
                    if (want.error_code != ERR_NONE) error_results <= error_results + 1;
                    if (want.error_code == ERR_TOO_MANY) too_many_hits <= too_many_hits + 1;
                    bad_fields = "";
                    if (got.data_byte !== want.data_byte)
                        bad_fields = {bad_fields, " data_byte"};
                    if (got.has_byte !== want.has_byte)
                        bad_fields = {bad_fields, " has_byte"};
                    if (got.field_end !== want.field_end)
                        bad_fields = {bad_fields, " field_end"};
                    if (got.record_end !== want.record_end)
                        bad_fields = {bad_fields, " record_end"};
                    if (got.field_index !== want.field_index)
                        bad_fields = {bad_fields, " field_index"};
                    if (got.error_code !== want.error_code)
                        bad_fields = {bad_fields, " error_code"};
                    if (bad_fields != "") begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch in%s", $realtime, bad_fields);
                            $display("  expected byte %h has %b fe %b re %b idx %0d err %0d",
                                     want.data_byte, want.has_byte, want.field_end,
                                     want.record_end, want.field_index, want.error_code);
                            $display("  actual   byte %h has %b fe %b re %b idx %0d err %0d",
                                     got.data_byte, got.has_byte, got.field_end,
                                     got.record_end, got.field_index, got.error_code);
                        end
                    end
                end
            end

            if (i_s_tvalid && o_s_tready) begin
                accepted_items <= accepted_items + 1;
                split_csv_byte(i_s_tdata, i_s_tlast, produced, want);
                if (produced) split_results_q.push_back(want);
            end
        end
    end

endmodule

[files.f]
rtl/core/csvfs_pkg.sv
rtl/core/csvfs_front.sv
rtl/core/csvfs_back.sv
rtl/core/csv_field_splitter_top.sv
test/tb_top.sv
